// ----- rtl/core/metp_pkg.sv -----
// Package for the escape-time pixel block: types, constants and saturating helpers.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
package metp_pkg;
	localparam int PIXEL_BITS_DEF  = 12;
	localparam int FRAC_BITS_DEF   = 58;
	localparam int ITER_BITS_DEF   = 16;
	localparam int WORD_BITS       = 64;
	localparam int CFG_IDX_BITS    = 3;
	localparam int QUEUE_DEPTH_LOG = 1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_REAL = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_IMAG = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_REAL   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_IMAG   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ITER_CAP    = 3'd4;

	localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// operations of the back-end sequencer
	typedef enum logic [3:0] {
		ST_IDLE, ST_MAP, ST_BULB0, ST_BULB1, ST_CARD0, ST_CARD1, ST_CARD2,
		ST_CARD3, ST_SQ, ST_TEST, ST_UPD0, ST_UPD1, ST_DONE
	} back_state_t;

	// saturating add and subtract
	function automatic logic [WORD_BITS-1:0] sadd(input logic [WORD_BITS-1:0] a,
			input logic [WORD_BITS-1:0] b);
		logic [WORD_BITS-1:0] r;
		r = a + b;
		if ((a[WORD_BITS-1] == b[WORD_BITS-1]) && (r[WORD_BITS-1] != a[WORD_BITS-1]))
			return a[WORD_BITS-1] ? SMIN : SMAX;
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] ssub(input logic [WORD_BITS-1:0] a,
			input logic [WORD_BITS-1:0] b);
		logic [WORD_BITS-1:0] r;
		r = a - b;
		if ((a[WORD_BITS-1] != b[WORD_BITS-1]) && (r[WORD_BITS-1] != a[WORD_BITS-1]))
			return a[WORD_BITS-1] ? SMIN : SMAX;
		return r;
	endfunction

	function automatic logic slt(input logic [WORD_BITS-1:0] a,
			input logic [WORD_BITS-1:0] b);
		return $signed(a) < $signed(b);
	endfunction
endpackage

// ----- rtl/core/metp_mul.sv -----
// Multi-cycle signed 64x64 multiplier: four 32x32 partial products, one per cycle, then
// a shift by FRAC_BITS when frac_mode is set, and saturation. Depends on metp_pkg.
`timescale 1ns / 1ps
module metp_mul #(
	parameter int FRAC_BITS = metp_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            frac_mode,
	input  logic [metp_pkg::WORD_BITS-1:0]  a,
	input  logic [metp_pkg::WORD_BITS-1:0]  b,
	output logic                            done,
	output logic [metp_pkg::WORD_BITS-1:0]  prod
);
	import metp_pkg::*;

	localparam int HB = WORD_BITS / 2;

	logic [WORD_BITS-1:0]   ma_q, mb_q;
	logic                   neg_q, frac_q;
	logic [2:0]             step_q;
	logic                   busy_q;
	logic [2*WORD_BITS-1:0] acc_q;
	logic [HB-1:0]          pa, pb;
	logic [WORD_BITS-1:0]   pp_q;
	logic signed [2*WORD_BITS-1:0] sacc;
	logic [2*WORD_BITS-1:0] shifted;
	logic [WORD_BITS-1:0]   hi;

	// pick the half-words for the current partial product
	always_comb begin
		pa = step_q[1] ? ma_q[WORD_BITS-1:HB] : ma_q[HB-1:0];
		pb = step_q[0] ? mb_q[WORD_BITS-1:HB] : mb_q[HB-1:0];
	end

	// sign, shift and saturate the finished magnitude
	always_comb begin
		sacc = neg_q ? (~acc_q + 1'b1) : acc_q;
		shifted = frac_q ? (sacc >>> FRAC_BITS) : sacc;
		hi = shifted[2*WORD_BITS-1:WORD_BITS];
		if (hi != {WORD_BITS{shifted[WORD_BITS-1]}})
			prod = hi[WORD_BITS-1] ? SMIN : SMAX;
		else
			prod = shifted[WORD_BITS-1:0];
	end

	// partial product register feeds the accumulator in the cycle after it is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= a[WORD_BITS-1] ? (~a + 1'b1) : a;
			mb_q   <= b[WORD_BITS-1] ? (~b + 1'b1) : b;
			neg_q  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			frac_q <= frac_mode;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4)
				pp_q <= pa * pb;
			if (step_q != 3'd0)
				acc_q <= acc_q + ({{WORD_BITS{1'b0}}, pp_q} <<
					(HB * ((step_q - 3'd1) == 3'd3 ? 2 :
					((step_q - 3'd1) == 3'd0 ? 0 : 1))));
		end
	end
endmodule

// ----- rtl/core/metp_front.sv -----
// Front end: accepts pixel items and writes them to a short queue.
// Depends on metp_pkg.
`timescale 1ns / 1ps
module metp_front #(
	parameter int PIXEL_BITS = metp_pkg::PIXEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PIXEL_BITS-1:0]   in_x,
	input  logic [PIXEL_BITS-1:0]   in_y,
	output logic                    q_valid,
	input  logic                    q_pop,
	output logic [PIXEL_BITS-1:0]   q_x,
	output logic [PIXEL_BITS-1:0]   q_y
);
	import metp_pkg::*;

	localparam int DEPTH_LOG = QUEUE_DEPTH_LOG;
	localparam int DEPTH     = 1 << DEPTH_LOG;

	logic [PIXEL_BITS-1:0] x_q [DEPTH];
	logic [PIXEL_BITS-1:0] y_q [DEPTH];
	logic [DEPTH_LOG-1:0]  wp_q, rp_q;
	logic [DEPTH_LOG:0]    cnt_q;
	logic                  push;

	assign in_ready = (cnt_q != DEPTH[DEPTH_LOG:0]);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_x      = x_q[rp_q];
	assign q_y      = y_q[rp_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			x_q[wp_q] <= in_x;
			y_q[wp_q] <= in_y;
		end
	end
endmodule

// ----- rtl/core/metp_back.sv -----
// Back end: maps a pixel to c, runs bulb and cardioid tests, then iterates.
// Depends on metp_pkg and metp_mul.
`timescale 1ns / 1ps
module metp_back #(
	parameter int PIXEL_BITS = metp_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = metp_pkg::FRAC_BITS_DEF,
	parameter int ITER_BITS  = metp_pkg::ITER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  logic [PIXEL_BITS-1:0]          q_x,
	input  logic [PIXEL_BITS-1:0]          q_y,
	input  logic [metp_pkg::WORD_BITS-1:0] origin_real,
	input  logic [metp_pkg::WORD_BITS-1:0] origin_imag,
	input  logic [metp_pkg::WORD_BITS-1:0] step_real,
	input  logic [metp_pkg::WORD_BITS-1:0] step_imag,
	input  logic [ITER_BITS-1:0]           iter_cap,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ITER_BITS-1:0]           out_count,
	output logic                           out_inside
);
	import metp_pkg::*;

	localparam logic [WORD_BITS-1:0] ONE     = WORD_BITS'(1) << FRAC_BITS;
	localparam logic [WORD_BITS-1:0] SIXTEEN = WORD_BITS'(1) << (FRAC_BITS - 4);
	localparam logic [WORD_BITS-1:0] QUARTER = WORD_BITS'(1) << (FRAC_BITS - 2);
	localparam logic [WORD_BITS-1:0] FOUR    = WORD_BITS'(4) << FRAC_BITS;

	back_state_t state_q, state_d;
	logic [WORD_BITS-1:0] cx_q, cy_q, zr_q, zi_q, t_q, u_q, cy2_q, dx_q, q_q;
	logic [ITER_BITS-1:0] i_q;
	logic [1:0] sub_q;

	// two multipliers run side by side
	logic m_start, m_done;
	logic m0_frac, m0_done, m1_done;
	logic [WORD_BITS-1:0] m0_a, m0_b, m1_a, m1_b, p0, p1;

	metp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(m_start), .frac_mode(m0_frac),
		.a(m0_a), .b(m0_b), .done(m0_done), .prod(p0));
	metp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(m_start), .frac_mode(m0_frac),
		.a(m1_a), .b(m1_b), .done(m1_done), .prod(p1));

	assign m_done = m0_done && m1_done;

	logic [WORD_BITS-1:0] zsum;
	assign zsum = sadd(t_q, u_q);

	// next state and multiplier operands
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		m_start = 1'b0;
		m0_frac = 1'b1;
		m0_a = cy_q; m0_b = cy_q; m1_a = cy_q; m1_b = cy_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					m_start = 1'b1;
					m0_frac = 1'b0;
					m0_a = step_real; m0_b = WORD_BITS'(q_x);
					m1_a = step_imag; m1_b = WORD_BITS'(q_y);
					state_d = ST_MAP;
				end
			end
			ST_MAP:   if (m_done) state_d = ST_BULB0;
			ST_BULB0: begin
				m_start = 1'b1;
				m0_a = sadd(cx_q, ONE); m0_b = sadd(cx_q, ONE);
				state_d = ST_BULB1;
			end
			ST_BULB1: if (m_done) state_d = ST_CARD0;
			ST_CARD0: begin
				if (slt(sadd(t_q, cy2_q), SIXTEEN)) state_d = ST_DONE;
				else begin
					m_start = 1'b1;
					m0_a = ssub(cx_q, QUARTER); m0_b = ssub(cx_q, QUARTER);
					state_d = ST_CARD1;
				end
			end
			ST_CARD1: if (m_done) state_d = ST_CARD2;
			ST_CARD2: begin
				m_start = 1'b1;
				m0_a = q_q; m0_b = sadd(q_q, dx_q);
				state_d = ST_CARD3;
			end
			ST_CARD3: begin
				if (m_done) begin
					if (slt(p0, {{2{cy2_q[WORD_BITS-1]}}, cy2_q[WORD_BITS-1:2]}))
						state_d = ST_DONE;
					else
						state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				if (i_q == iter_cap) state_d = ST_DONE;
				else begin
					m_start = 1'b1;
					m0_a = zr_q; m0_b = zr_q; m1_a = zi_q; m1_b = zi_q;
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sub_q == 2'd1) begin
					if (slt(FOUR, zsum)) state_d = ST_DONE;
					else begin
						m_start = 1'b1;
						m0_a = sadd(zr_q, zr_q); m0_b = zi_q;
						state_d = ST_UPD0;
					end
				end
			end
			ST_UPD0:  if (m_done) state_d = ST_SQ;
			ST_DONE:  if (out_ready || !out_valid) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			sub_q     <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q == ST_DONE && (out_ready || !out_valid)) out_valid <= 1'b1;
			state_q <= state_d;
			// squares are taken when both products are ready, then compared in the following cycle
			if (state_q == ST_TEST)
				sub_q <= (sub_q == 2'd1) ? 2'd0 : (m_done ? 2'd1 : 2'd0);
			else sub_q <= 2'd0;
		end
	end

	// datapath registers; a bulb or cardioid hit sets the count to the cap
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				zr_q <= '0; zi_q <= '0; i_q <= '0;
			end
			ST_MAP: if (m_done) begin
				cx_q <= sadd(origin_real, p0);
				cy_q <= sadd(origin_imag, p1);
			end
			ST_BULB1: if (m_done) begin
				t_q <= p0; cy2_q <= p1;
			end
			ST_CARD0: begin
				dx_q <= ssub(cx_q, QUARTER);
				if (slt(sadd(t_q, cy2_q), SIXTEEN)) i_q <= iter_cap;
			end
			ST_CARD1: if (m_done) q_q <= sadd(p0, cy2_q);
			ST_CARD3: if (m_done && slt(p0, {{2{cy2_q[WORD_BITS-1]}}, cy2_q[WORD_BITS-1:2]}))
				i_q <= iter_cap;
			ST_TEST: if (sub_q == 2'd0 && m_done) begin
				t_q <= p0; u_q <= p1;
			end
			ST_UPD0: if (m_done) begin
				zi_q <= sadd(p0, cy_q);
				zr_q <= sadd(ssub(t_q, u_q), cx_q);
				i_q  <= i_q + 1'b1;
			end
			ST_DONE: if (out_ready || !out_valid) begin
				out_count  <= i_q;
				out_inside <= (i_q == iter_cap);
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/mandelbrot_escape_time_pixel.sv -----
// Escape-time pixel top level: config registers, two-entry input queue, iterating back end.
// Each multiply forms four 32x32 partial products, and a step needs two multiplies.
// One item in the back end at a time; it pops the next item the cycle after its result
// enters the output register. Reset (arst_n low): view registers zero, cap 256, queue empty.
`timescale 1ns / 1ps
module mandelbrot_escape_time_pixel #(
	parameter int PIXEL_BITS = metp_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = metp_pkg::FRAC_BITS_DEF,
	parameter int ITER_BITS  = metp_pkg::ITER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pixel_x, pixel_y
	input  logic [((2*PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// iteration_count, inside_set
	output logic [((ITER_BITS+1+7)/8)*8-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [metp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [metp_pkg::WORD_BITS-1:0]   cfg_data
);
	import metp_pkg::*;

	localparam int OUT_W = ((ITER_BITS + 1 + 7) / 8) * 8;

	logic [WORD_BITS-1:0] origin_real_q, origin_imag_q, step_real_q, step_imag_q;
	logic [ITER_BITS-1:0] iter_cap_q;
	logic q_valid, q_pop, in_set;
	logic [PIXEL_BITS-1:0] q_x, q_y;
	logic [ITER_BITS-1:0] count;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q <= '0;
			origin_imag_q <= '0;
			step_real_q   <= '0;
			step_imag_q   <= '0;
			iter_cap_q    <= ITER_BITS'(256);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_REAL: origin_real_q <= cfg_data;
				REG_ORIGIN_IMAG: origin_imag_q <= cfg_data;
				REG_STEP_REAL:   step_real_q   <= cfg_data;
				REG_STEP_IMAG:   step_imag_q   <= cfg_data;
				REG_ITER_CAP:    iter_cap_q    <= cfg_data[ITER_BITS-1:0];
				default: ;
			endcase
		end
	end

	metp_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_x(s_axis_tdata[PIXEL_BITS-1:0]),
		.in_y(s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
		.q_valid(q_valid), .q_pop(q_pop), .q_x(q_x), .q_y(q_y));

	metp_back #(.PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS), .ITER_BITS(ITER_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_x(q_x), .q_y(q_y),
		.origin_real(origin_real_q), .origin_imag(origin_imag_q),
		.step_real(step_real_q), .step_imag(step_imag_q), .iter_cap(iter_cap_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_count(count), .out_inside(in_set));

	assign m_axis_tdata = OUT_W'({in_set, count});

	// a pop only happens when the queue holds an item
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	// a result held under back-pressure keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
endmodule
